@@ rtl/r2t_pkg.sv @@
// Shared types and constants of the radix integer-to-text formatter.
// Used by r2t_div and radix_integer_to_text; no dependencies.
package r2t_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int MAX_CHARS_DEFAULT   = 64;

   // Bits retired by the divider in one cycle.
   localparam int DIV_BITS_PER_CYCLE = 8;

   localparam int RADIX_W    = 5;
   localparam int MIN_W      = 7;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIGITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_CHAR  = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [CHAR_W-1:0]  FILL_RESET  = 8'd48;

   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  ASCII_A     = 8'h41;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

   typedef struct packed {
      logic               start;
      logic [RADIX_W-1:0] radix;
   } r2t_div_ctl_type;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] rem;
   } r2t_div_status_type;

endpackage

@@ rtl/r2t_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the digits of the formatter.
module r2t_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/r2t_div.sv @@
// Iterative restoring divider of a wide value by a small radix.
// Depends on r2t_pkg for the control and status structs.
module r2t_div #(
   parameter int VALUE_WIDTH = r2t_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  r2t_pkg::r2t_div_ctl_type    div_ctl,
   input  logic [VALUE_WIDTH-1:0]      dividend,
   output r2t_pkg::r2t_div_status_type div_status,
   output logic [VALUE_WIDTH-1:0]      quotient
);
   import r2t_pkg::*;

   localparam int N_CYC = (VALUE_WIDTH + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
   localparam int PAD_W = N_CYC * DIV_BITS_PER_CYCLE;
   localparam int CNT_W = $clog2(N_CYC + 1);

   logic [PAD_W-1:0]   quo_ff;
   logic [DIGIT_W-1:0] rem_ff;
   logic [RADIX_W-1:0] radix_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   logic [PAD_W-1:0]   step_q;
   logic [RADIX_W-1:0] step_r;

   // The dividend is shifted out at the top while quotient bits enter at the bottom.
   always_comb begin
      step_q = quo_ff;
      step_r = {1'b0, rem_ff};
      for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
         step_r = {step_r[DIGIT_W-1:0], step_q[PAD_W-1]};
         step_q = {step_q[PAD_W-2:0], 1'b0};
         if (step_r >= radix_ff) begin
            step_r    = step_r - radix_ff;
            step_q[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff   <= '0;
         rem_ff   <= '0;
         radix_ff <= RADIX_RESET;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_ctl.start) begin
            quo_ff   <= PAD_W'(dividend);
            rem_ff   <= '0;
            radix_ff <= div_ctl.radix;
            cnt_ff   <= CNT_W'(N_CYC);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            quo_ff <= step_q;
            rem_ff <= step_r[DIGIT_W-1:0];
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_status.done = done_ff;
   assign div_status.rem  = rem_ff;
   assign quotient        = quo_ff[VALUE_WIDTH-1:0];

   a_done_follows_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a preceding busy cycle");

endmodule

@@ rtl/radix_integer_to_text.sv @@
// Top level of the radix integer-to-text formatter.
// Depends on r2t_pkg, r2t_div and r2t_ram.
//
// An item on the req_ channel carries one unsigned value. The block converts
// it in the radix held in the csr_ registers and sends one character per rsp_
// item: first fill characters up to the minimum length, then the digits most
// significant first, with rsp_last set on the final one.
// The conversion runs on one shared divider that retires eight dividend bits
// a cycle and yields one digit per division. After the digits, a planning
// state follows; then each fill character is sent straight from the send
// state, while each digit first passes a fetch state, as the digit store
// has a registered read port.
// req_ready is high only while the block is idle; the final character may
// still wait in the output register when the next item is accepted.
// A stalled receiver simply holds the block in its emit phase.
// Reset is synchronous; it restores radix ten, no minimum and a fill of '0'.
// Configuration is to be written only while the block is idle.
module radix_integer_to_text #(
   parameter int VALUE_WIDTH = r2t_pkg::VALUE_WIDTH_DEFAULT,
   parameter int MAX_CHARS   = r2t_pkg::MAX_CHARS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [VALUE_WIDTH-1:0]           req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [r2t_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [r2t_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [r2t_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import r2t_pkg::*;

   localparam int AW  = $clog2(VALUE_WIDTH);
   localparam int DCW = $clog2(VALUE_WIDTH + 1);
   localparam logic [MIN_W-1:0] MAX_C = MIN_W'(MAX_CHARS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PLAN,
      ST_FETCH,
      ST_SEND
   } state_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      if (d < DIGIT_TEN) begin
         digit_char = ASCII_ZERO + CHAR_W'(d);
      end else begin
         digit_char = ASCII_A + CHAR_W'(d - DIGIT_TEN);
      end
   endfunction

   // Configuration registers
   logic [RADIX_W-1:0] radix_ff;
   logic [MIN_W-1:0]   min_digits_ff;
   logic [CHAR_W-1:0]  fill_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RESET;
         min_digits_ff <= '0;
         fill_char_ff  <= FILL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RADIX:      radix_ff      <= csr_wdata[RADIX_W-1:0];
            CSR_MIN_DIGITS: min_digits_ff <= csr_wdata[MIN_W-1:0];
            CSR_FILL_CHAR:  fill_char_ff  <= csr_wdata[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   state_type          state_ff, state_in;
   logic [DCW-1:0]     digit_count_ff, digit_count_in;
   logic [MIN_W-1:0]   emit_index_ff, emit_index_in;
   logic [MIN_W-1:0]   pad_ff, pad_in;
   logic [MIN_W-1:0]   total_ff, total_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   r2t_div_ctl_type    div_ctl;
   r2t_div_status_type div_status;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_quotient;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [DIGIT_W-1:0] ram_rd_data;

   logic [RADIX_W-1:0] eff_radix;
   logic [MIN_W-1:0]   min_sat;
   logic [MIN_W-1:0]   count_ext;
   logic [MIN_W-1:0]   pad_calc;
   logic [MIN_W:0]     sum_calc;
   logic [MIN_W-1:0]   total_calc;
   logic               slot_free;
   logic               is_pad;
   logic               is_last;
   logic [MIN_W-1:0]   next_index;

   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         eff_radix = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         eff_radix = RADIX_MAX;
      end else begin
         eff_radix = radix_ff;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Length of the field: padding, digits and the output bound.
   assign min_sat    = (min_digits_ff > MAX_C) ? MAX_C : min_digits_ff;
   assign count_ext  = MIN_W'(digit_count_ff);
   assign pad_calc   = (min_sat > count_ext) ? (min_sat - count_ext) : '0;
   assign sum_calc   = {1'b0, pad_calc} + {1'b0, count_ext};
   assign total_calc = (sum_calc > {1'b0, MAX_C}) ? MAX_C : sum_calc[MIN_W-1:0];

   assign next_index = emit_index_ff + MIN_W'(1);
   assign is_pad     = emit_index_ff < pad_ff;
   assign is_last    = next_index == total_ff;

   assign div_ctl.start = ((state_ff == ST_IDLE) && req_valid)
                       || ((state_ff == ST_DIVIDE) && div_status.done
                           && (div_quotient != '0));
   assign div_ctl.radix = eff_radix;
   assign div_dividend  = (state_ff == ST_IDLE) ? req_value : div_quotient;

   assign ram_wr_en = (state_ff == ST_DIVIDE) && div_status.done;
   assign ram_rd_en = (state_ff == ST_FETCH);

   always_comb begin
      state_in       = state_ff;
      digit_count_in = digit_count_ff;
      emit_index_in  = emit_index_ff;
      pad_in         = pad_ff;
      total_in       = total_ff;
      rd_ptr_in      = rd_ptr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               digit_count_in = '0;
               state_in       = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               digit_count_in = digit_count_ff + DCW'(1);
               if (div_quotient == '0) begin
                  state_in = ST_PLAN;
               end
            end
         end
         ST_PLAN: begin
            pad_in        = pad_calc;
            total_in      = total_calc;
            emit_index_in = '0;
            rd_ptr_in     = AW'(digit_count_ff - DCW'(1));
            state_in      = (pad_calc != '0) ? ST_SEND : ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = is_pad ? fill_char_ff : digit_char(ram_rd_data);
               rsp_last_in   = is_last;
               emit_index_in = next_index;
               if (!is_pad) begin
                  rd_ptr_in = rd_ptr_ff - AW'(1);
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end else if (next_index < pad_ff) begin
                  state_in = ST_SEND;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         digit_count_ff <= '0;
         emit_index_ff  <= '0;
         pad_ff         <= '0;
         total_ff       <= '0;
         rd_ptr_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_char_ff    <= '0;
         rsp_last_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         digit_count_ff <= digit_count_in;
         emit_index_ff  <= emit_index_in;
         pad_ff         <= pad_in;
         total_ff       <= total_in;
         rd_ptr_ff      <= rd_ptr_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_char_ff    <= rsp_char_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   r2t_div #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .div_ctl    (div_ctl),
      .dividend   (div_dividend),
      .div_status (div_status),
      .quotient   (div_quotient)
   );

   r2t_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (VALUE_WIDTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (digit_count_ff[AW-1:0]),
      .wr_data (div_status.rem),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIVIDE))
      else $error("accepted item did not start a division");

   a_emit_within_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (emit_index_ff < total_ff))
      else $error("character index ran past the field length");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SEND) && slot_free && is_last)
         |=> ((state_ff == ST_IDLE) && rsp_valid && rsp_last))
      else $error("final character not marked or block not idle");

   a_digit_count_bound: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= DCW'(VALUE_WIDTH))
      else $error("digit count exceeds the digit store");

endmodule
